[hdl/tcld_pkg.sv]
package tcld_pkg;

	localparam int LEVEL_W = 14;
	localparam int BAL_W = 11;
	localparam int TICK_W = 16;
	localparam int SLOT_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [LEVEL_W-1:0] LEVEL_TOP = 14'd16383;
	localparam logic [BAL_W-1:0] BAL_FULL = 11'd1024;

	localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FLOOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BALANCE_LOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BALANCE_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DECISION = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ADJUST_STEP = 3'd7;

	localparam logic [1:0] MIX_MONO = 2'd0;
	localparam logic [1:0] MIX_DUAL = 2'd1;
	localparam logic [1:0] MIX_GLOW = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE, PH_DEBOUNCE, PH_DECIDE, PH_HOLD, PH_GAP,
		PH_RAMP_ON, PH_RAMP_OFF, PH_RISE, PH_ADJUST, PH_BALANCE
	} phase_t;

	typedef enum logic [2:0] {
		MX_IDLE, MX_SQ, MX_E, MX_MIX, MX_DONE
	} mix_state_t;

	typedef struct packed {
		logic [1:0] mix_mode;
		logic [LEVEL_W-1:0] level_floor;
		logic [BAL_W-1:0] balance_low;
		logic [BAL_W-1:0] balance_high;
		logic [TICK_W-1:0] debounce_ticks;
		logic [TICK_W-1:0] decision_ticks;
		logic [TICK_W-1:0] ramp_step_ticks;
		logic [TICK_W-1:0] adjust_step_ticks;
	} cfg_t;

	// snapshot handed from the gesture front to the duty back end
	typedef struct packed {
		logic active;
		logic on_flag;
		logic [LEVEL_W-1:0] level;
		logic [BAL_W-1:0] balance;
		logic [1:0] mix_mode;
	} snap_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] ch1_duty;
		logic [LEVEL_W-1:0] ch2_duty;
		logic lamp_on;
		logic [LEVEL_W-1:0] level_now;
	} result_t;

endpackage

[hdl/tcld_gesture.sv]
module tcld_gesture #(
	parameter int SLOT_TICKS = 25,
	parameter int GESTURE_SLOTS = 10,
	parameter int BALANCE_STEP_TICKS = 10,
	parameter int BOOT_LEVEL = 8192,
	parameter int INIT_BALANCE = 512
) (
	input logic clk,
	input logic arst_n,
	input logic tick_valid,
	input logic button_pressed,
	input tcld_pkg::cfg_t cfg,
	output tcld_pkg::snap_t snap
);
	import tcld_pkg::*;

	phase_t phase_q;
	logic on_q, lvl_up_q, bal_up_q;
	logic [LEVEL_W-1:0] level_q, saved_q;
	logic [BAL_W-1:0] bal_q;
	logic [TICK_W-1:0] tick_q;
	logic [SLOT_W-1:0] slot_q;

	phase_t phase_d;
	logic on_d, lvl_up_d, bal_up_d;
	logic [LEVEL_W-1:0] level_d, saved_d;
	logic [BAL_W-1:0] bal_d;
	logic [TICK_W-1:0] tick_d;
	logic [SLOT_W-1:0] slot_d;

	logic [TICK_W-1:0] tick_inc, ramp_per, adj_per;
	logic [SLOT_W-1:0] slot_inc;
	logic slot_tick, slots_done, ramp_done, adj_done, bal_done;

	assign tick_inc = tick_q + 1'b1;
	assign slot_inc = slot_q + 1'b1;
	assign ramp_per = (cfg.ramp_step_ticks == '0) ? TICK_W'(1) : cfg.ramp_step_ticks;
	assign adj_per = (cfg.adjust_step_ticks == '0) ? TICK_W'(1) : cfg.adjust_step_ticks;
	assign slot_tick = 32'(tick_inc) >= 32'(SLOT_TICKS);
	assign slots_done = slot_tick && (32'(slot_inc) >= 32'(GESTURE_SLOTS));
	assign ramp_done = tick_inc >= ramp_per;
	assign adj_done = tick_inc >= adj_per;
	assign bal_done = 32'(tick_inc) >= 32'(BALANCE_STEP_TICKS);

	always_comb begin
		phase_d = phase_q;
		on_d = on_q;
		lvl_up_d = lvl_up_q;
		bal_up_d = bal_up_q;
		level_d = level_q;
		saved_d = saved_q;
		bal_d = bal_q;
		tick_d = tick_q;
		slot_d = slot_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (button_pressed) begin
					phase_d = PH_DEBOUNCE; tick_d = '0; slot_d = '0;
				end
			end
			PH_DEBOUNCE: begin
				if (!button_pressed) begin
					phase_d = PH_IDLE; tick_d = '0; slot_d = '0;
				end else if (tick_q >= cfg.debounce_ticks) begin
					phase_d = on_q ? PH_HOLD : PH_DECIDE; tick_d = '0; slot_d = '0;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_DECIDE: begin
				if (tick_q < cfg.decision_ticks) begin
					tick_d = tick_inc;
				end else if (button_pressed) begin
					level_d = '0; on_d = 1'b1; lvl_up_d = 1'b1;
					phase_d = PH_RISE; tick_d = '0; slot_d = '0;
				end else begin
					saved_d = level_q; level_d = '0;
					phase_d = PH_RAMP_ON; tick_d = '0; slot_d = '0;
				end
			end
			PH_HOLD: begin
				if (!button_pressed) begin
					phase_d = PH_GAP; tick_d = '0; slot_d = '0;
				end else if (slots_done) begin
					phase_d = PH_ADJUST; tick_d = '0; slot_d = '0;
				end else begin
					tick_d = slot_tick ? '0 : tick_inc;
					slot_d = slot_tick ? slot_inc : slot_q;
				end
			end
			PH_GAP: begin
				if (button_pressed) begin
					tick_d = '0; slot_d = '0;
					if (cfg.mix_mode == MIX_DUAL) begin
						phase_d = PH_BALANCE;
					end else begin
						saved_d = level_q; phase_d = PH_RAMP_OFF;
					end
				end else if (slots_done) begin
					saved_d = level_q; phase_d = PH_RAMP_OFF; tick_d = '0; slot_d = '0;
				end else begin
					tick_d = slot_tick ? '0 : tick_inc;
					slot_d = slot_tick ? slot_inc : slot_q;
				end
			end
			PH_RAMP_ON: begin
				if (level_q >= saved_q) begin
					level_d = saved_q; on_d = 1'b1;
					phase_d = PH_IDLE; tick_d = '0; slot_d = '0;
				end else if (ramp_done) begin
					tick_d = '0; level_d = level_q + 1'b1;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_RAMP_OFF: begin
				if (level_q == '0) begin
					level_d = saved_q; on_d = 1'b0;
					phase_d = PH_IDLE; tick_d = '0; slot_d = '0;
				end else if (ramp_done) begin
					tick_d = '0; level_d = level_q - 1'b1;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_RISE: begin
				if (level_q >= cfg.level_floor) begin
					phase_d = PH_ADJUST; tick_d = '0; slot_d = '0;
				end else if (adj_done) begin
					tick_d = '0; level_d = level_q + 1'b1;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_ADJUST: begin
				if (!button_pressed) begin
					lvl_up_d = !lvl_up_q; phase_d = PH_IDLE; tick_d = '0; slot_d = '0;
				end else if (adj_done) begin
					tick_d = '0;
					if (lvl_up_q && level_q < LEVEL_TOP) level_d = level_q + 1'b1;
					else if (!lvl_up_q && level_q > cfg.level_floor) level_d = level_q - 1'b1;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_BALANCE: begin
				if (!button_pressed) begin
					bal_up_d = !bal_up_q; phase_d = PH_IDLE; tick_d = '0; slot_d = '0;
				end else if (bal_done) begin
					tick_d = '0;
					if (bal_up_q && bal_q < cfg.balance_high) bal_d = bal_q + 1'b1;
					else if (!bal_up_q && bal_q > cfg.balance_low) bal_d = bal_q - 1'b1;
				end else begin
					tick_d = tick_inc;
				end
			end
			default: begin
				phase_d = PH_IDLE; tick_d = '0; slot_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			on_q <= 1'b0;
			lvl_up_q <= 1'b1;
			bal_up_q <= 1'b1;
			level_q <= LEVEL_W'(BOOT_LEVEL);
			saved_q <= '0;
			bal_q <= BAL_W'(INIT_BALANCE);
			tick_q <= '0;
			slot_q <= '0;
		end else if (tick_valid) begin
			phase_q <= phase_d;
			on_q <= on_d;
			lvl_up_q <= lvl_up_d;
			bal_up_q <= bal_up_d;
			level_q <= level_d;
			saved_q <= saved_d;
			bal_q <= bal_d;
			tick_q <= tick_d;
			slot_q <= slot_d;
		end
	end

	assign snap.active = on_d || (phase_d == PH_RAMP_ON);
	assign snap.on_flag = on_d;
	assign snap.level = level_d;
	assign snap.balance = bal_d;
	assign snap.mix_mode = cfg.mix_mode;

endmodule

[hdl/tcld_snap_fifo.sv]
module tcld_snap_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input tcld_pkg::snap_t push_data,
	output logic full,
	input logic pop,
	output tcld_pkg::snap_t pop_data,
	output logic empty
);
	import tcld_pkg::*;

	snap_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= !wr_q;
			if (pop && !empty) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

endmodule

[hdl/tcld_duty.sv]
module tcld_duty (
	input logic clk,
	input logic arst_n,
	input logic snap_empty,
	input tcld_pkg::snap_t snap,
	output logic snap_pop,
	input logic res_pop,
	output tcld_pkg::result_t res,
	output logic res_empty
);
	import tcld_pkg::*;

	mix_state_t st_q, st_d;
	snap_t cur_q;
	logic [27:0] prod_q;
	logic [LEVEL_W-1:0] e_q;
	result_t res_q;
	logic full_q;

	logic [LEVEL_W-1:0] mul_a, mul_b;
	logic [27:0] prod;
	logic [LEVEL_W-1:0] e_sat, c1;
	logic [BAL_W-1:0] bal_sat;
	logic load, finish;

	assign bal_sat = (cur_q.balance > BAL_FULL) ? BAL_FULL : cur_q.balance;
	assign e_sat = (prod_q[27:14] > LEVEL_TOP) ? LEVEL_TOP : prod_q[27:14];
	assign c1 = LEVEL_W'(prod_q >> 10);

	// one shared multiplier: level squared, then the mix product
	always_comb begin
		mul_a = cur_q.level;
		mul_b = cur_q.level;
		if (st_q == MX_MIX) begin
			mul_a = e_q;
			mul_b = (cur_q.mix_mode == MIX_DUAL) ? LEVEL_W'(bal_sat) : e_q;
		end
	end
	assign prod = mul_a * mul_b;

	always_comb begin
		st_d = st_q;
		load = 1'b0;
		finish = 1'b0;
		unique case (st_q)
			MX_IDLE: if (!snap_empty) begin load = 1'b1; st_d = MX_SQ; end
			MX_SQ: st_d = MX_E;
			MX_E: st_d = MX_MIX;
			MX_MIX: st_d = MX_DONE;
			MX_DONE: if (!full_q || res_pop) begin finish = 1'b1; st_d = MX_IDLE; end
			default: st_d = MX_IDLE;
		endcase
	end
	assign snap_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= MX_IDLE;
			full_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (finish) full_q <= 1'b1;
			else if (res_pop) full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) cur_q <= snap;
		if (st_q == MX_SQ || st_q == MX_MIX) prod_q <= prod;
		if (st_q == MX_E) e_q <= e_sat;
		if (finish) begin
			res_q.lamp_on <= cur_q.on_flag;
			res_q.level_now <= cur_q.level;
			if (!cur_q.active) begin
				res_q.ch1_duty <= '0;
				res_q.ch2_duty <= '0;
			end else if (cur_q.mix_mode == MIX_DUAL) begin
				res_q.ch1_duty <= c1;
				res_q.ch2_duty <= e_q - c1;
			end else if (cur_q.mix_mode == MIX_GLOW) begin
				res_q.ch1_duty <= e_q;
				res_q.ch2_duty <= prod_q[27:14];
			end else begin
				res_q.ch1_duty <= e_q;
				res_q.ch2_duty <= e_q;
			end
		end
	end

	assign res = res_q;
	assign res_empty = !full_q;

endmodule

[hdl/two_channel_led_dimmer_controller_core.sv]
// channel   direction   handshake     payload
// tick      in          push / full   button_pressed
// result    out         empty / pop   ch1_duty ch2_duty lamp_on level_now
// config    in          cfg_we        cfg_idx cfg_data
// the gesture machine takes one tick per cycle while the snapshot queue has room
// each result passes through the duty unit's SQ, E, MIX and DONE states (two passes through one 14x14 multiplier)
// the duty unit takes a new snapshot only once the last result has left DONE; the two-entry queue absorbs bursts
// arst_n clears all control state; results stall in a one-entry output register
module two_channel_led_dimmer_controller_core #(
	parameter int SLOT_TICKS = 25,
	parameter int GESTURE_SLOTS = 10,
	parameter int BALANCE_STEP_TICKS = 10,
	parameter int BOOT_LEVEL = 8192,
	parameter int INIT_BALANCE = 512
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic button_pressed,
	output logic empty,
	input logic pop,
	output logic [tcld_pkg::LEVEL_W-1:0] ch1_duty,
	output logic [tcld_pkg::LEVEL_W-1:0] ch2_duty,
	output logic lamp_on,
	output logic [tcld_pkg::LEVEL_W-1:0] level_now,
	input logic cfg_we,
	input logic [tcld_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [tcld_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tcld_pkg::*;

	cfg_t cfg_q;
	snap_t snap_in, snap_out;
	result_t res;
	logic q_empty, q_pop, accept;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mix_mode <= MIX_MONO;
			cfg_q.level_floor <= LEVEL_W'(64);
			cfg_q.balance_low <= '0;
			cfg_q.balance_high <= BAL_FULL;
			cfg_q.debounce_ticks <= TICK_W'(50);
			cfg_q.decision_ticks <= TICK_W'(300);
			cfg_q.ramp_step_ticks <= TICK_W'(1);
			cfg_q.adjust_step_ticks <= TICK_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MIX_MODE: cfg_q.mix_mode <= cfg_data[1:0];
				REG_LEVEL_FLOOR: cfg_q.level_floor <= cfg_data[LEVEL_W-1:0];
				REG_BALANCE_LOW: cfg_q.balance_low <= cfg_data[BAL_W-1:0];
				REG_BALANCE_HIGH: cfg_q.balance_high <= cfg_data[BAL_W-1:0];
				REG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_data;
				REG_DECISION: cfg_q.decision_ticks <= cfg_data;
				REG_RAMP_STEP: cfg_q.ramp_step_ticks <= cfg_data;
				REG_ADJUST_STEP: cfg_q.adjust_step_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	tcld_gesture #(
		.SLOT_TICKS(SLOT_TICKS),
		.GESTURE_SLOTS(GESTURE_SLOTS),
		.BALANCE_STEP_TICKS(BALANCE_STEP_TICKS),
		.BOOT_LEVEL(BOOT_LEVEL),
		.INIT_BALANCE(INIT_BALANCE)
	) u_gesture (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(accept),
		.button_pressed(button_pressed),
		.cfg(cfg_q),
		.snap(snap_in)
	);

	tcld_snap_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(snap_in),
		.full(full),
		.pop(q_pop),
		.pop_data(snap_out),
		.empty(q_empty)
	);

	tcld_duty u_duty (
		.clk(clk),
		.arst_n(arst_n),
		.snap_empty(q_empty),
		.snap(snap_out),
		.snap_pop(q_pop),
		.res_pop(pop),
		.res(res),
		.res_empty(empty)
	);

	assign ch1_duty = res.ch1_duty;
	assign ch2_duty = res.ch2_duty;
	assign lamp_on = res.lamp_on;
	assign level_now = res.level_now;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(ch1_duty) && $stable(ch2_duty)
			&& $stable(lamp_on) && $stable(level_now))
		else $error("result changed while stalled");
	a_queue_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue underflow");

endmodule
